/* rtl/usrr_pkg.sv */
// Shared types, request codes and descriptor tables of the standard request responder.
`default_nettype none

package usrr_pkg;

  // Largest reply buffer the block honors; larger buffer sizes are clipped to it.
  localparam int unsigned MaxBuffer = 64;

  // Depth of the command queue between the decoder and the reply streamer.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);

  // Descriptor lengths in bytes.
  localparam logic [5:0] DevDescLen = 6'd18;
  localparam logic [5:0] CfgDescLen = 6'd32;

  // Standard request codes (bRequest).
  localparam logic [7:0] ReqGetStatus    = 8'h00;
  localparam logic [7:0] ReqClearFeature = 8'h01;
  localparam logic [7:0] ReqSetFeature   = 8'h03;
  localparam logic [7:0] ReqSetAddress   = 8'h05;
  localparam logic [7:0] ReqGetDesc      = 8'h06;
  localparam logic [7:0] ReqGetConfig    = 8'h08;
  localparam logic [7:0] ReqSetConfig    = 8'h09;
  localparam logic [7:0] ReqSetInterface = 8'h0B;

  // Request type field of bmRequestType and descriptor types of wValue.
  localparam logic [1:0] TypeStandard = 2'd0;
  localparam logic [7:0] DescDevice   = 8'h01;
  localparam logic [7:0] DescConfig   = 8'h02;

  typedef enum logic [1:0] {
    StData  = 2'd0,
    StAck   = 2'd1,
    StStall = 2'd2
  } reply_status_e;

  typedef enum logic [1:0] {
    SrcConst  = 2'd0,
    SrcDevice = 2'd1,
    SrcConfig = 2'd2
  } byte_src_e;

  // One decoded request. A count of zero means a single ack or stall result.
  typedef struct packed {
    byte_src_e     src;
    logic [5:0]    count;
    reply_status_e status;
    logic [7:0]    data;
    logic [6:0]    address;
  } cmd_t;

  // Device descriptor, padded with zeros past its 18 bytes.
  localparam logic [7:0] DevRom [32] = '{
    8'd18, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08,
    8'h5E, 8'h04, 8'h89, 8'h02, 8'h21, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Configuration descriptor: configuration, interface and two interrupt endpoints.
  localparam logic [7:0] CfgRom [32] = '{
    8'd9,  8'h02, 8'd32, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80,
    8'd50, 8'd9,  8'h04, 8'h00, 8'h00, 8'h02, 8'h58, 8'h42,
    8'h00, 8'h00, 8'd7,  8'h05, 8'h81, 8'h03, 8'h20, 8'h00,
    8'h04, 8'd7,  8'h05, 8'h02, 8'h03, 8'h20, 8'h00, 8'h04
  };

endpackage

`default_nettype wire

/* rtl/usrr_if.sv */
// Valid/ready channel interfaces for setup packets and reply beats.
`default_nettype none

interface usrr_setup_if;
  logic        valid;
  logic        ready;
  logic [7:0]  request_type_byte;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_length;
  logic [6:0]  buffer_max;

  modport source (
    output valid, request_type_byte, request_code, request_value, request_length,
           buffer_max,
    input  ready
  );
  modport sink (
    input  valid, request_type_byte, request_code, request_value, request_length,
           buffer_max,
    output ready
  );
endinterface

interface usrr_reply_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_status;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic       last_of_reply;
  logic [6:0] current_address;

  modport source (
    output valid, reply_status, data_byte, byte_index, last_of_reply, current_address,
    input  ready
  );
  modport sink (
    input  valid, reply_status, data_byte, byte_index, last_of_reply, current_address,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/usb_standard_request_responder.sv */
// Top level of the endpoint-zero standard request responder.
// The setup channel takes one setup packet per beat: bmRequestType, bRequest,
// wValue, wLength and the size of the reply buffer. The reply channel gives one
// beat per reply byte, or a single beat for a zero-length acknowledge or a
// stall; last_of_reply marks the final beat of each reply, and every beat
// carries the device address as it stands after its request.
// A setup packet is decoded in the cycle it is accepted and its command is
// written into a two-entry queue; the streamer takes the command from the
// queue head and presents each reply beat from the output register. A reply
// of n bytes gives n beats (a single beat for an acknowledge or stall), one
// descriptor table read per cycle while the receiver is ready.
// The decoder keeps accepting setup packets while the queue has room, even
// when a finished beat waits in the output register.
// Reset clears the device address, the configuration value, the queue and the
// output valid flag. When the receiver holds ready low, the current beat stays
// in place, the streamer pauses, and setup ready drops once the queue is full.
`default_nettype none

module usb_standard_request_responder (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  usrr_setup_if.sink   setup_i,
  usrr_reply_if.source reply_o
);

  usrr_pkg::cmd_t push_cmd;
  usrr_pkg::cmd_t head_cmd;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  // Decoder: classifies the request, updates the address and configuration.
  usrr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .setup_i    (setup_i),
    .cmd_full_i (full),
    .cmd_push_o (push),
    .cmd_o      (push_cmd)
  );

  // Queue that lets the decoder and the streamer stall independently.
  usrr_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (empty)
  );

  // Streamer: walks the reply byte by byte into the output register.
  usrr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .reply_o (reply_o)
  );

endmodule

`default_nettype wire

/* rtl/usrr_front.sv */
// Request decoder: accepts setup packets, keeps device state and emits commands.
`default_nettype none

module usrr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  usrr_setup_if.sink         setup_i,
  input  wire logic          cmd_full_i,
  output      logic          cmd_push_o,
  output      usrr_pkg::cmd_t cmd_o
);

  logic [6:0] addr_q, addr_d;
  logic [7:0] cfg_q, cfg_d;
  logic [6:0] buf_c;
  logic [5:0] desc_n;
  logic       accept;
  logic       is_in;
  logic       standard;
  logic [5:0] rom_len;

  assign setup_i.ready = !cmd_full_i;
  assign accept        = setup_i.valid && !cmd_full_i;
  assign cmd_push_o    = accept;

  assign is_in    = setup_i.request_type_byte[7];
  assign standard = (setup_i.request_type_byte[6:5] == usrr_pkg::TypeStandard);

  // Clip the buffer size to the largest buffer the block supports.
  always_comb begin
    if ({1'b0, setup_i.buffer_max} > 8'(usrr_pkg::MaxBuffer)) begin
      buf_c = 7'(usrr_pkg::MaxBuffer);
    end else begin
      buf_c = setup_i.buffer_max;
    end
  end

  // Descriptor byte count: least of descriptor length, wLength and buffer.
  always_comb begin
    rom_len = (setup_i.request_value[15:8] == usrr_pkg::DescDevice) ?
              usrr_pkg::DevDescLen : usrr_pkg::CfgDescLen;
    desc_n  = rom_len;
    if (setup_i.request_length < {10'd0, desc_n}) begin
      desc_n = setup_i.request_length[5:0];
    end
    if ({1'b0, buf_c} < {1'b0, desc_n}) begin
      desc_n = buf_c[5:0];
    end
  end

  always_comb begin
    addr_d          = addr_q;
    cfg_d           = cfg_q;
    cmd_o.src       = usrr_pkg::SrcConst;
    cmd_o.count     = 6'd0;
    cmd_o.status    = usrr_pkg::StStall;
    cmd_o.data      = 8'd0;
    if (standard) begin
      unique case (setup_i.request_code) inside
        usrr_pkg::ReqGetDesc: begin
          if (is_in && setup_i.request_value[15:8] == usrr_pkg::DescDevice) begin
            cmd_o.src    = usrr_pkg::SrcDevice;
            cmd_o.count  = desc_n;
            cmd_o.status = usrr_pkg::StAck;
          end else if (is_in && setup_i.request_value[15:8] == usrr_pkg::DescConfig) begin
            cmd_o.src    = usrr_pkg::SrcConfig;
            cmd_o.count  = desc_n;
            cmd_o.status = usrr_pkg::StAck;
          end
        end
        usrr_pkg::ReqSetAddress: begin
          addr_d       = setup_i.request_value[6:0];
          cmd_o.status = usrr_pkg::StAck;
        end
        usrr_pkg::ReqSetConfig: begin
          cfg_d        = setup_i.request_value[7:0];
          cmd_o.status = usrr_pkg::StAck;
        end
        usrr_pkg::ReqGetConfig: begin
          if (is_in && buf_c != 7'd0) begin
            cmd_o.count = 6'd1;
            cmd_o.data  = cfg_q;
          end
        end
        usrr_pkg::ReqGetStatus: begin
          if (is_in && buf_c >= 7'd2) begin
            cmd_o.count = 6'd2;
          end
        end
        usrr_pkg::ReqClearFeature,
        usrr_pkg::ReqSetFeature,
        usrr_pkg::ReqSetInterface: begin
          cmd_o.status = usrr_pkg::StAck;
        end
        default: begin
          cmd_o.status = usrr_pkg::StStall;
        end
      endcase
    end
    cmd_o.address = addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 7'd0;
      cfg_q  <= 8'd0;
    end else if (accept) begin
      addr_q <= addr_d;
      cfg_q  <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/usrr_cmd_fifo.sv */
// Short command queue between the request decoder and the reply streamer.
`default_nettype none

module usrr_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire usrr_pkg::cmd_t push_cmd_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      usrr_pkg::cmd_t head_o,
  output      logic           empty_o
);

  usrr_pkg::cmd_t                mem_q [usrr_pkg::CmdDepth];
  logic [usrr_pkg::CmdPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [usrr_pkg::CmdPtrW:0]    count_q;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == (usrr_pkg::CmdPtrW+1)'(usrr_pkg::CmdDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == usrr_pkg::CmdPtrW'(usrr_pkg::CmdDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == usrr_pkg::CmdPtrW'(usrr_pkg::CmdDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/usrr_back.sv */
// Reply streamer: turns queued commands into reply beats held in an output register.
`default_nettype none

module usrr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire usrr_pkg::cmd_t head_i,
  input  wire logic           empty_i,
  output      logic           pop_o,
  usrr_reply_if.source        reply_o
);

  logic       valid_q;
  logic [4:0] idx_q;
  logic       advance;
  logic       single;
  logic       last;
  logic [7:0] src_byte;

  logic [1:0] status_q;
  logic [7:0] data_q;
  logic [4:0] index_q;
  logic       last_q;
  logic [6:0] addr_q;

  assign advance = !valid_q || reply_o.ready;
  assign single  = (head_i.count == 6'd0);
  assign last    = single || ((6'(idx_q) + 6'd1) == head_i.count);
  assign pop_o   = advance && !empty_i && last;

  always_comb begin
    case (head_i.src)
      usrr_pkg::SrcDevice: src_byte = usrr_pkg::DevRom[idx_q];
      usrr_pkg::SrcConfig: src_byte = usrr_pkg::CfgRom[idx_q];
      default:             src_byte = head_i.data;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 5'd0;
    end else if (advance) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= last ? 5'd0 : idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !empty_i) begin
      status_q <= single ? head_i.status : usrr_pkg::StData;
      data_q   <= single ? 8'd0 : src_byte;
      index_q  <= single ? 5'd0 : idx_q;
      last_q   <= last;
      addr_q   <= head_i.address;
    end
  end

  assign reply_o.valid           = valid_q;
  assign reply_o.reply_status    = status_q;
  assign reply_o.data_byte       = data_q;
  assign reply_o.byte_index      = index_q;
  assign reply_o.last_of_reply   = last_q;
  assign reply_o.current_address = addr_q;

endmodule

`default_nettype wire
